/* design/gccdp_pkg.sv */
`default_nettype none

package gccdp_pkg;

  localparam int unsigned CoinsWidth  = 8;
  localparam int unsigned ScoreWidth  = 17;
  localparam int unsigned SizeWidth   = 9;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned EntryWidth  = ScoreWidth + 1;

  localparam int unsigned DefMaxCols = 256;
  localparam int unsigned DefMaxRows = 256;

  localparam logic [SizeWidth-1:0] GridColsReset = SizeWidth'(8);
  localparam logic [SizeWidth-1:0] GridRowsReset = SizeWidth'(8);

  localparam logic [ScoreWidth-1:0] ScoreMax = {ScoreWidth{1'b1}};

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_GRID_COLS = CfgIdxWidth'(0),
    CFG_GRID_ROWS = CfgIdxWidth'(1)
  } cfg_idx_e;

  typedef struct packed {
    logic [CoinsWidth-1:0] coins;
    logic                  blocked;
  } in_beat_t;

  typedef struct packed {
    logic [ScoreWidth-1:0] cell_score;
    logic                  reachable;
    logic                  last_cell;
  } out_beat_t;

  typedef struct packed {
    logic top_row;
    logic left_col;
    logic last;
  } pos_flags_t;

endpackage

`default_nettype wire

/* design/gccdp_pos.sv */
`default_nettype none

module gccdp_pos #(
  parameter int unsigned MAX_COLS = gccdp_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = gccdp_pkg::DefMaxRows
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [gccdp_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [gccdp_pkg::SizeWidth-1:0]       cfg_data_i,
  input  wire logic                                  acc_i,
  output logic [$clog2(MAX_COLS)-1:0]                addr_o,
  output gccdp_pkg::pos_flags_t                      flags_o
);
  import gccdp_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_COLS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CXW = (CW > SizeWidth) ? CW : SizeWidth;
  localparam int unsigned RXW = (RCW > SizeWidth) ? RCW : SizeWidth;

  logic [SizeWidth-1:0] grid_cols_q, grid_rows_q;
  logic [AW-1:0]        col_pos_q, col_pos_d;
  logic [RW-1:0]        row_pos_q, row_pos_d;

  logic [CXW-1:0] cols_x;
  logic [RXW-1:0] rows_x;
  logic [CW-1:0]  cols;
  logic [RCW-1:0] rows;
  logic           col_wrap;
  logic [CW-1:0]  col_cur, col_nxt;
  logic [RCW-1:0] row_tmp, row_cur, row_nxt;

  always_comb begin
    cols_x = CXW'(grid_cols_q);
    rows_x = RXW'(grid_rows_q);
    if (cols_x == '0) begin
      cols = CW'(1);
    end else if (cols_x > CXW'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = cols_x[CW-1:0];
    end
    if (rows_x == '0) begin
      rows = RCW'(1);
    end else if (rows_x > RXW'(MAX_ROWS)) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = rows_x[RCW-1:0];
    end

    col_wrap = (CW'(col_pos_q) >= cols);
    col_cur  = col_wrap ? '0 : CW'(col_pos_q);
    row_tmp  = col_wrap ? RCW'(row_pos_q) + RCW'(1) : RCW'(row_pos_q);
    row_cur  = (row_tmp >= rows) ? '0 : row_tmp;

    col_nxt = col_cur + CW'(1);
    row_nxt = row_cur;
    if (col_nxt >= cols) begin
      col_nxt = '0;
      row_nxt = row_cur + RCW'(1);
      if (row_nxt >= rows) begin
        row_nxt = '0;
      end
    end
    col_pos_d = col_nxt[AW-1:0];
    row_pos_d = row_nxt[RW-1:0];

    addr_o           = col_cur[AW-1:0];
    flags_o.top_row  = (row_cur == '0);
    flags_o.left_col = (col_cur == '0);
    flags_o.last     = (col_cur == cols - CW'(1)) && (row_cur == rows - RCW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GridColsReset;
      grid_rows_q <= GridRowsReset;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
          CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc_i) begin
        col_pos_q <= col_pos_d;
        row_pos_q <= row_pos_d;
      end
    end
  end

endmodule

`default_nettype wire

/* design/gccdp_line.sv */
`default_nettype none

module gccdp_line #(
  parameter int unsigned MAX_COLS = gccdp_pkg::DefMaxCols
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic [$clog2(MAX_COLS)-1:0] addr_i,
  input  wire gccdp_pkg::pos_flags_t       flags_i,
  input  wire gccdp_pkg::in_beat_t         cell_i,
  input  wire logic                        adv_i,
  output logic                             s1_valid_o,
  output gccdp_pkg::out_beat_t             res_o
);
  import gccdp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_COLS);

  logic [EntryWidth-1:0] mem [MAX_COLS];

  logic                  s1_valid_q;
  logic [AW-1:0]         s1_addr_q;
  pos_flags_t            s1_flags_q;
  in_beat_t              s1_cell_q;
  logic [EntryWidth-1:0] rdata_q;
  logic [EntryWidth-1:0] fwd_data_q;
  logic                  fwd_hit_q;
  logic [ScoreWidth-1:0] left_score_q;
  logic                  left_reach_q;

  logic [EntryWidth-1:0] up_entry;
  logic                  up_reach, lf_reach, reach, wr_en;
  logic [ScoreWidth-1:0] best, score;
  logic [ScoreWidth:0]   sum;

  always_comb begin
    up_entry = fwd_hit_q ? fwd_data_q : rdata_q;
    up_reach = !s1_flags_q.top_row && up_entry[0];
    lf_reach = !s1_flags_q.left_col && left_reach_q;
    if (s1_cell_q.blocked) begin
      reach = 1'b0;
    end else if (s1_flags_q.top_row && s1_flags_q.left_col) begin
      reach = 1'b1;
    end else begin
      reach = up_reach || lf_reach;
    end
    best = up_reach ? up_entry[EntryWidth-1:1] : '0;
    if (lf_reach && (left_score_q > best)) begin
      best = left_score_q;
    end
    sum = {1'b0, best} + (ScoreWidth + 1)'(s1_cell_q.coins);
    if (!reach) begin
      score = '0;
    end else if (sum[ScoreWidth]) begin
      score = ScoreMax;
    end else begin
      score = sum[ScoreWidth-1:0];
    end
    wr_en = s1_valid_q && adv_i;

    res_o.cell_score = score;
    res_o.reachable  = reach;
    res_o.last_cell  = s1_flags_q.last;
    s1_valid_o       = s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= {score, reach};
    end
    if (acc_i) begin
      rdata_q    <= mem[addr_i];
      fwd_data_q <= {score, reach};
      s1_addr_q  <= addr_i;
      s1_flags_q <= flags_i;
      s1_cell_q  <= cell_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_hit_q    <= 1'b0;
      left_score_q <= '0;
      left_reach_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= wr_en && (s1_addr_q == addr_i);
      end else if (wr_en) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        left_score_q <= score;
        left_reach_q <= reach;
      end
    end
  end

endmodule

`default_nettype wire

/* design/grid_coin_collection_dp_unit.sv */
// An accepted input beat is registered in the line stage and then in the output register.
// Throughput: one cell per cycle while the output is not stalled, set by a single read and
// a single write of the line buffer per cell, with forwarding when consecutive cells share a column.
// Reset clears the position, the pipeline valid bits and the left neighbor, and
// loads both grid sizes with 8; the line buffer itself is not cleared.
`default_nettype none

module grid_coin_collection_dp_unit #(
  parameter int unsigned MAX_COLS = gccdp_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = gccdp_pkg::DefMaxRows
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gccdp_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [gccdp_pkg::SizeWidth-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire gccdp_pkg::in_beat_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output gccdp_pkg::out_beat_t                   out_data_o
);
  import gccdp_pkg::*;

  logic                        acc, s1_valid, s1_adv;
  logic [$clog2(MAX_COLS)-1:0] addr;
  pos_flags_t                  flags;
  out_beat_t                   res;
  logic                        out_valid_q;
  out_beat_t                   out_data_q;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid && !s1_adv;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  gccdp_pos #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .addr_o     (addr),
    .flags_o    (flags)
  );

  gccdp_line #(
    .MAX_COLS(MAX_COLS)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .addr_i    (addr),
    .flags_i   (flags),
    .cell_i    (in_data_i),
    .adv_i     (s1_adv),
    .s1_valid_o(s1_valid),
    .res_o     (res)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* design/gccdp_checker.sv */
`default_nettype none

module gccdp_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire gccdp_pkg::out_beat_t out_data_o
);
  import gccdp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Result payload changed while stalled.");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled with the output register empty.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i |=> out_valid_o)
    else $error("Accepted beat did not reach the output in time.");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reachable |-> out_data_o.cell_score == '0)
    else $error("Unreachable cell carries a nonzero score.");

endmodule

bind grid_coin_collection_dp_unit gccdp_checker u_gccdp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gccdp_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [SizeWidth-1:0]   cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_data;

  in_beat_t  cells_pending[$];
  out_beat_t scores_due[$];
  out_beat_t want;

  logic [SizeWidth-1:0]  cols_reg = GridColsReset;
  logic [SizeWidth-1:0]  rows_reg = GridRowsReset;
  logic [EntryWidth-1:0] line_buf [DefMaxCols];
  logic [ScoreWidth-1:0] left_score = '0;
  logic                  left_reach = 1'b0;
  int unsigned           pos_col = 0;
  int unsigned           pos_row = 0;

  int unsigned cycle_count = 0;
  int unsigned cells_queued = 0;
  int unsigned cells_sent = 0;
  int unsigned grids_done = 0;
  int unsigned bad_beats = 0;
  int unsigned phases = 0;
  int unsigned mid_changes = 0;
  int          tx_gap = 0;
  int          tx_calm = 0;
  int          rx_stall = 0;
  int          rx_calm = 0;

  always #4 clk_i = ~clk_i;

  grid_coin_collection_dp_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  function automatic int unsigned eff_size(logic [SizeWidth-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic out_beat_t score_cell(in_beat_t item);
    int unsigned           cols;
    int unsigned           rows;
    logic [ScoreWidth-1:0] up_score;
    logic [ScoreWidth-1:0] lf_score;
    logic [ScoreWidth-1:0] best;
    logic                  up_reach;
    logic                  lf_reach;
    logic                  reach;
    logic [ScoreWidth:0]   total;
    out_beat_t             res;
    cols = eff_size(cols_reg, DefMaxCols);
    rows = eff_size(rows_reg, DefMaxRows);
    up_score = '0;
    up_reach = 1'b0;
    lf_score = '0;
    lf_reach = 1'b0;
    if (pos_col >= cols) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= rows) pos_row = 0;
    if (pos_row > 0) {up_score, up_reach} = line_buf[pos_col];
    if (pos_col > 0) begin
      lf_score = left_score;
      lf_reach = left_reach;
    end
    if (item.blocked) begin
      reach = 1'b0;
    end else if (pos_row == 0 && pos_col == 0) begin
      reach = 1'b1;
    end else begin
      reach = up_reach | lf_reach;
    end
    res.cell_score = '0;
    if (reach) begin
      best = '0;
      if (up_reach) best = up_score;
      if (lf_reach && lf_score > best) best = lf_score;
      total = best + item.coins;
      res.cell_score = (total > ScoreMax) ? ScoreMax : total[ScoreWidth-1:0];
    end
    res.reachable = reach;
    res.last_cell = (pos_col == cols - 1) && (pos_row == rows - 1);
    line_buf[pos_col] = {res.cell_score, reach};
    left_score = res.cell_score;
    left_reach = reach;
    pos_col++;
    if (pos_col >= cols) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= rows) pos_row = 0;
    end
    return res;
  endfunction

  function automatic int pick_idle(ref int calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 10) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_cell(logic [CoinsWidth-1:0] coins, logic blocked);
    in_beat_t item;
    item.coins = coins;
    item.blocked = blocked;
    cells_pending.push_back(item);
    cells_queued++;
  endtask

  task automatic queue_cells(int unsigned n, int unsigned block_pct);
    int unsigned r;
    logic [CoinsWidth-1:0] coins;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) coins = '0;
      else if (r == 1) coins = '1;
      else coins = CoinsWidth'($urandom_range(0, 255));
      push_cell(coins, $urandom_range(0, 99) < block_pct);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cells_pending.size() != 0 || in_valid || scores_due.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [SizeWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_COLS) cols_reg = val;
    else if (idx == CFG_GRID_ROWS) rows_reg = val;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, scores_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        scores_due.push_back(score_cell(in_data));
        cells_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (cells_pending.size() != 0) begin
          in_data  <= cells_pending.pop_front();
          in_valid <= 1'b1;
          tx_gap = pick_idle(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (scores_due.size() == 0) begin
          bad_beats++;
          $display("%0t: result beat with nothing expected: score %0d reach %0b last %0b",
                   $time, out_data.cell_score, out_data.reachable, out_data.last_cell);
        end else begin
          want = scores_due.pop_front();
          if (want.last_cell) grids_done++;
          if (want.cell_score !== out_data.cell_score || want.reachable !== out_data.reachable ||
              want.last_cell !== out_data.last_cell) begin
            bad_beats++;
            $display("%0t: expected score %0d reach %0b last %0b, got score %0d reach %0b last %0b",
                     $time, want.cell_score, want.reachable, want.last_cell,
                     out_data.cell_score, out_data.reachable, out_data.last_cell);
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_stall = pick_idle(rx_calm);
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned cols_pick;
    int unsigned rows_pick;
    int unsigned grid_cells;
    int unsigned n;
    int unsigned block_pct;
    for (int i = 0; i < DefMaxCols; i++) line_buf[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first grid runs at the sizes loaded by reset.
    @(negedge clk_i);
    queue_cells(64, 10);
    wait_drained();

    write_reg(CFG_GRID_COLS, SizeWidth'(3));
    write_reg(CFG_GRID_ROWS, SizeWidth'(2));
    write_reg(CfgIdxSpare, '1);
    @(negedge clk_i);
    push_cell('1, 1'b1);
    push_cell('1, 1'b0);
    push_cell('1, 1'b0);
    push_cell('1, 1'b0);
    push_cell('1, 1'b0);
    push_cell('1, 1'b0);
    push_cell('1, 1'b0);
    push_cell('0, 1'b0);
    push_cell('1, 1'b0);
    push_cell('0, 1'b1);
    push_cell('1, 1'b0);
    push_cell('1, 1'b0);
    wait_drained();

    write_reg(CFG_GRID_COLS, '0);
    write_reg(CFG_GRID_ROWS, SizeWidth'(1));
    @(negedge clk_i);
    push_cell('1, 1'b0);
    push_cell('0, 1'b1);
    push_cell('0, 1'b0);
    wait_drained();

    // One full-width row writes every line buffer entry, so later size
    // changes inside a grid never read an entry that was never written.
    write_reg(CFG_GRID_COLS, '1);
    write_reg(CFG_GRID_ROWS, '0);
    @(negedge clk_i);
    queue_cells(DefMaxCols, 2);
    wait_drained();

    write_reg(CFG_GRID_COLS, SizeWidth'(1));
    write_reg(CFG_GRID_ROWS, SizeWidth'(DefMaxRows));
    @(negedge clk_i);
    queue_cells(DefMaxRows, 3);
    wait_drained();
    phases = 5;

    while (cells_queued < 750) begin
      r = $urandom_range(0, 99);
      if (r < 8) cols_pick = DefMaxCols;
      else if (r < 12) cols_pick = 0;
      else if (r < 16) cols_pick = $urandom_range(DefMaxCols + 1, 511);
      else cols_pick = $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      if (r < 8) rows_pick = DefMaxRows;
      else if (r < 12) rows_pick = 0;
      else if (r < 16) rows_pick = $urandom_range(DefMaxRows + 1, 511);
      else rows_pick = $urandom_range(1, 10);
      if (pos_col != 0 || pos_row != 0) mid_changes++;
      r = $urandom_range(0, 99);
      if (r < 87) write_reg(CFG_GRID_COLS, SizeWidth'(cols_pick));
      if (r < 75 || r >= 87) write_reg(CFG_GRID_ROWS, SizeWidth'(rows_pick));
      if ($urandom_range(0, 19) == 0) write_reg(CfgIdxSpare, SizeWidth'($urandom_range(0, 511)));
      grid_cells = eff_size(cols_reg, DefMaxCols) * eff_size(rows_reg, DefMaxRows);
      if (grid_cells <= 64) begin
        n = grid_cells * $urandom_range(1, 4);
        if ($urandom_range(0, 9) < 3) n += $urandom_range(0, grid_cells - 1);
      end else begin
        n = $urandom_range(10, 100);
      end
      r = $urandom_range(0, 99);
      if (r < 50) block_pct = 8;
      else if (r < 75) block_pct = 20;
      else if (r < 90) block_pct = 0;
      else block_pct = 50;
      @(negedge clk_i);
      queue_cells(n, block_pct);
      wait_drained();
      phases++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d cells over %0d size settings; %0d grids completed.",
             cells_sent, phases, grids_done);
    $display("Sizes changed inside a grid %0d times; %0d bad result beats.",
             mid_changes, bad_beats);
    if (bad_beats == 0 && scores_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
design/gccdp_pkg.sv
design/gccdp_pos.sv
design/gccdp_line.sv
design/grid_coin_collection_dp_unit.sv
design/gccdp_checker.sv
tb/tb_top.sv
